@@ rtl/mexp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

  // default widths of exponent and modulus
  localparam int DEF_EXP_BITS = 32;
  localparam int DEF_MOD_BITS = 30;

  // modulus after reset (a prime)
  localparam logic [63:0] MEXP_RESET_MODULUS = 64'd998244353;

endpackage : mexp_pkg

`default_nettype wire

@@ rtl/modular_exponentiation.sv @@
`timescale 1ns / 1ps
`default_nettype none

// modular exponentiation: each input item (base, exponent) gives one output item
// power_result = base ^ exponent mod modulus, using right-to-left binary
// square-and-multiply. the modulus is a register written through cfg_wr_en /
// cfg_wr_data and resets to 998244353; write it only while the block is idle.
// every modular product runs on one shared interleaved shift-add-reduce unit
// that retires one multiplier bit per cycle. an item first reduces the base,
// then for each of the EXP_BITS exponent bits goes through a step state,
// multiplies when the bit is set and then squares, so the time per item
// depends on the number of set exponent bits. a last step state finds the
// exponent done, and the result is loaded into the output register once that
// register is free; the next item can be taken after that. a modulus below 2
// gives 0 without running any products. the input is stalled while an item
// is in work; a finished result sits in the output register so the next
// item can be taken while it waits.
module modular_exponentiation #(
  parameter int EXP_BITS = mexp_pkg::DEF_EXP_BITS,
  parameter int MOD_BITS = mexp_pkg::DEF_MOD_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration
  input  wire logic                cfg_wr_en,
  input  wire logic [MOD_BITS-1:0] cfg_wr_data,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [MOD_BITS-1:0] in_base_value,
  input  wire logic [EXP_BITS-1:0] in_exponent,
  // output channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [MOD_BITS-1:0]      out_power_result
);

  import mexp_pkg::*;

  localparam int CNT_W = (MOD_BITS > 1) ? $clog2(MOD_BITS) : 1;
  localparam int BIT_W = $clog2(EXP_BITS + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MOD_BITS - 1);
  localparam logic [BIT_W-1:0] EXP_COUNT = BIT_W'(EXP_BITS);
  localparam logic [MOD_BITS-1:0] RESET_MOD = MOD_BITS'(MEXP_RESET_MODULUS);
  localparam logic [MOD_BITS-1:0] ONE = MOD_BITS'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_NEXT,
    ST_MUL,
    ST_SQR,
    ST_OUT
  } state_t;

  state_t state_r;

  // modulus register
  logic [MOD_BITS-1:0] modulus_r;

  // item working registers
  logic [EXP_BITS-1:0] exp_r;
  logic [BIT_W-1:0]    bits_left_r;
  logic [MOD_BITS-1:0] acc_r;       // running result
  logic [MOD_BITS-1:0] sq_r;        // running square of the base

  // shared modular multiplier: mm_acc = mm_acc*2 + ybit*mm_x, reduced each cycle
  logic [MOD_BITS-1:0] mm_acc_r;
  logic [MOD_BITS-1:0] mm_x_r;      // addend, always below the modulus
  logic [MOD_BITS-1:0] mm_y_r;      // multiplier, consumed msb first
  logic [CNT_W-1:0]    mm_cnt_r;

  // output register
  logic                out_valid_r;
  logic [MOD_BITS-1:0] out_result_r;

  // one step of the shared unit
  logic [MOD_BITS:0]   mod_ext;
  logic [MOD_BITS:0]   dbl;
  logic [MOD_BITS:0]   dbl_red;
  logic [MOD_BITS:0]   sum;
  logic [MOD_BITS:0]   sum_red;
  logic [MOD_BITS-1:0] mm_acc_nxt;
  logic                mm_last;
  logic                out_free;

  // product setup for the shared unit
  logic                mod_small;
  logic                mm_load;
  logic [MOD_BITS-1:0] mm_x_ld;
  logic [MOD_BITS-1:0] mm_y_ld;

  always_comb begin
    mod_ext    = {1'b0, modulus_r};
    dbl        = {mm_acc_r, 1'b0};
    dbl_red    = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
    sum        = dbl_red + (mm_y_r[MOD_BITS-1] ? {1'b0, mm_x_r} : '0);
    sum_red    = (sum >= mod_ext) ? (sum - mod_ext) : sum;
    mm_acc_nxt = sum_red[MOD_BITS-1:0];
  end

  assign mm_last   = (mm_cnt_r == LAST_STEP);
  // degenerate modulus, everything is congruent to zero
  assign mod_small = (modulus_r < MOD_BITS'(2));
  // output register can take a new result this cycle
  assign out_free  = !out_valid_r || !out_stall;

  // the unit restarts when a product is set up, otherwise it keeps stepping
  always_comb begin
    mm_load = 1'b0;
    mm_x_ld = sq_r;
    mm_y_ld = sq_r;
    unique case (state_r)
      ST_IDLE: begin
        // base mod m computed as 1 * base
        mm_load = in_valid && !mod_small;
        mm_x_ld = ONE;
        mm_y_ld = in_base_value;
      end
      ST_NEXT: begin
        mm_load = 1'b1;
        mm_y_ld = exp_r[0] ? acc_r : sq_r;
      end
      // go straight on to squaring
      ST_MUL: mm_load = mm_last;
      default: mm_load = 1'b0;
    endcase
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_power_result = out_result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      modulus_r   <= RESET_MOD;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        modulus_r <= cfg_wr_data;
      end

      // new result loaded, or output item taken
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (mm_load) begin
        mm_acc_r <= '0;
        mm_x_r   <= mm_x_ld;
        mm_y_r   <= mm_y_ld;
        mm_cnt_r <= '0;
      end else begin
        mm_acc_r <= mm_acc_nxt;
        mm_y_r   <= {mm_y_r[MOD_BITS-2:0], 1'b0};
        mm_cnt_r <= mm_cnt_r + CNT_W'(1);
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            exp_r <= in_exponent;
            if (mod_small) begin
              acc_r       <= '0;
              bits_left_r <= '0;
              state_r     <= ST_NEXT;
            end else begin
              acc_r       <= ONE;
              bits_left_r <= EXP_COUNT;
              state_r     <= ST_REDUCE;
            end
          end
        end

        ST_REDUCE: begin
          if (mm_last) begin
            sq_r    <= mm_acc_nxt;
            state_r <= ST_NEXT;
          end
        end

        ST_NEXT: begin
          if (bits_left_r == '0) begin
            state_r <= ST_OUT;
          end else if (exp_r[0]) begin
            state_r <= ST_MUL;
          end else begin
            state_r <= ST_SQR;
          end
        end

        ST_MUL: begin
          if (mm_last) begin
            acc_r   <= mm_acc_nxt;
            state_r <= ST_SQR;
          end
        end

        ST_SQR: begin
          if (mm_last) begin
            sq_r        <= mm_acc_nxt;
            exp_r       <= exp_r >> 1;
            bits_left_r <= bits_left_r - BIT_W'(1);
            state_r     <= ST_NEXT;
          end
        end

        ST_OUT: begin
          // wait here only if the previous result is still held
          if (out_free) begin
            out_result_r <= acc_r;
            state_r      <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule : modular_exponentiation

`default_nettype wire
